// ----- hw/rtl/ibpu_pkg.sv -----
// Shared types and constants of the indexed bitmap pixel unpacker.
// No dependencies; used by the channel interfaces and the core.
package ibpu_pkg;

    // Input item: palette entry write or raster byte
    typedef struct packed {
        logic       mode;
        logic [7:0] palette_index;
        logic [7:0] entry_red;
        logic [7:0] entry_green;
        logic [7:0] entry_blue;
        logic [7:0] raster_byte;
    } t_item;

    // Result item: one decoded pixel
    typedef struct packed {
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
        logic        last_of_byte;
        logic        image_done;
    } t_pixel;

    // Item modes
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_RASTER  = 1'b1;

    // Pixel depth codes
    localparam logic [1:0] DEPTH_1BIT = 2'd0;
    localparam logic [1:0] DEPTH_4BIT = 2'd1;
    localparam logic [1:0] DEPTH_8BIT = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_DEPTH  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // Register reset values
    localparam logic [1:0]  RST_DEPTH  = DEPTH_8BIT;
    localparam logic [11:0] RST_WIDTH  = 12'd1024;
    localparam logic [11:0] RST_HEIGHT = 12'd768;

    // Upper bound on width and height
    localparam int DIM_CAP = 2048;

endpackage

// ----- hw/rtl/ibpu_if.sv -----
// Valid/ready channel interfaces for input items and decoded pixels.
// Depends on ibpu_pkg for the payload types.
interface ibpu_item_if import ibpu_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ibpu_pixel_if import ibpu_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/indexed_bitmap_pixel_unpacker_core.sv -----
// Indexed bitmap pixel unpacker core: palette store, raster byte unpacking, APB registers.
// Depends on ibpu_pkg and the channel interfaces in ibpu_if.sv.
//
// One input transfer carries either a palette entry write or one raster byte of a
// bottom-up bitmap at 1, 4 or 8 bits per pixel. A raster byte occupies the unpack stage
// until the last pixel it emits has moved on (up to 8 at one bit per pixel, 2 at four,
// 1 at eight), since pixels leave one per cycle while the output is not stalled, through
// the single read port of the palette memory and the output register. The next item is
// taken in the cycle that the last pixel of the current byte moves to the output
// register; palette writes, padding bytes and bytes past the image do not occupy the
// unpack stage. A byte is first held in the unpack stage, and each of its pixels then
// moves through the palette read port into the output register, one after the other
// while the output is not stalled. Palette entries that were never written return
// undefined colors. Registers may be written only while the block is idle; the row and
// byte counters are kept across writes.
module indexed_bitmap_pixel_unpacker_core import ibpu_pkg::*; #(
    parameter int MAX_WIDTH     = 2048,
    parameter int MAX_HEIGHT    = 2048,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    ibpu_item_if.sink     i_item,
    ibpu_pixel_if.source  o_pixel
);

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0]  PAL_LIMIT = 9'(PALETTE_DEPTH);
    localparam logic [11:0] WIDTH_TOP =
        12'((MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP);
    localparam logic [11:0] HEIGHT_TOP =
        12'((MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP);

    // Configuration registers
    logic [1:0]  r_depth;
    logic [11:0] r_width;
    logic [11:0] r_height;

    // Image position
    logic [10:0] r_byte_in_row;
    logic [11:0] r_rows_done;

    // Unpack stage
    logic        r_a_busy;
    logic [7:0]  r_a_byte;
    logic [3:0]  r_a_cnt;
    logic [10:0] r_a_x;
    logic [10:0] r_a_y;
    logic        r_a_imgend;
    logic [1:0]  r_a_depth;

    // Output stage
    logic        r_ovalid;
    logic [10:0] r_ox;
    logic [10:0] r_oy;
    logic        r_olast;
    logic        r_odone;
    logic        r_ozero;
    logic [23:0] r_rgb;

    // Palette memory
    logic [23:0] r_pal [PALETTE_DEPTH];

    logic        cfg_wr;
    logic [11:0] w_width;
    logic [11:0] w_height;
    logic [3:0]  ppb;
    logic [13:0] x0;
    logic [11:0] row_bytes;
    logic [12:0] row_sum;
    logic [12:0] row_len;
    logic        img_open;
    logic        x_ok;
    logic [13:0] rem;
    logic [3:0]  n_cnt;
    logic        last_row;
    logic        img_end;
    logic [11:0] y_full;
    logic [11:0] byte_next;
    logic        row_wrap;
    logic        a_adv;
    logic        a_last;
    logic        in_fire;
    logic        raster_fire;
    logic        pal_we;
    logic [7:0]  cidx;
    logic [7:0]  n_a_byte;

    // APB write and read back
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= RST_DEPTH;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_DEPTH:  r_depth  <= pwdata[1:0];
                REG_WIDTH:  r_width  <= pwdata[11:0];
                REG_HEIGHT: r_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEPTH:  prdata = {30'd0, r_depth};
            REG_WIDTH:  prdata = {20'd0, r_width};
            REG_HEIGHT: prdata = {20'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    // Clamp the image size
    always_comb begin
        if (r_width == 12'd0) begin
            w_width = 12'd1;
        end else if (r_width > WIDTH_TOP) begin
            w_width = WIDTH_TOP;
        end else begin
            w_width = r_width;
        end
        if (r_height == 12'd0) begin
            w_height = 12'd1;
        end else if (r_height > HEIGHT_TOP) begin
            w_height = HEIGHT_TOP;
        end else begin
            w_height = r_height;
        end
    end

    // Pixels per byte, first column of this byte, bytes per row
    always_comb begin
        case (r_depth)
            DEPTH_1BIT: begin
                ppb       = 4'd8;
                x0        = {r_byte_in_row, 3'b000};
                row_bytes = 12'((13'(w_width) + 13'd7) >> 3);
            end
            DEPTH_4BIT: begin
                ppb       = 4'd2;
                x0        = {2'b00, r_byte_in_row, 1'b0};
                row_bytes = 12'((13'(w_width) + 13'd1) >> 1);
            end
            default: begin
                ppb       = 4'd1;
                x0        = {3'b000, r_byte_in_row};
                row_bytes = w_width;
            end
        endcase
    end

    // Round the row up to four bytes, count the pixels this byte emits
    assign row_sum   = {1'b0, row_bytes} + 13'd3;
    assign row_len   = {row_sum[12:2], 2'b00};
    assign img_open  = r_rows_done < w_height;
    assign x_ok      = x0 < {2'b00, w_width};
    assign rem       = {2'b00, w_width} - x0;
    assign n_cnt     = !x_ok ? 4'd0 : ((rem > {10'd0, ppb}) ? ppb : rem[3:0]);
    assign last_row  = r_rows_done == (w_height - 12'd1);
    assign img_end   = last_row && x_ok && (rem <= {10'd0, ppb});
    assign y_full    = w_height - 12'd1 - r_rows_done;
    assign byte_next = {1'b0, r_byte_in_row} + 12'd1;
    assign row_wrap  = {1'b0, byte_next} >= row_len;

    // Handshake: take the next item as the current byte finishes
    assign a_adv        = r_a_busy && (!r_ovalid || o_pixel.ready);
    assign a_last       = r_a_cnt == 4'd1;
    assign i_item.ready = !r_a_busy || (a_adv && a_last);
    assign in_fire      = i_item.valid && i_item.ready;
    assign raster_fire  = in_fire && (i_item.data.mode == MODE_RASTER) && img_open;
    assign pal_we       = in_fire && (i_item.data.mode == MODE_PALETTE) &&
                          ({1'b0, i_item.data.palette_index} < PAL_LIMIT);

    // Color index at the top of the byte, then shift it out
    always_comb begin
        case (r_a_depth)
            DEPTH_1BIT: begin
                cidx     = {7'd0, r_a_byte[7]};
                n_a_byte = {r_a_byte[6:0], 1'b0};
            end
            DEPTH_4BIT: begin
                cidx     = {4'd0, r_a_byte[7:4]};
                n_a_byte = {r_a_byte[3:0], 4'd0};
            end
            default: begin
                cidx     = r_a_byte;
                n_a_byte = r_a_byte;
            end
        endcase
    end

    // Advance the row position on each raster byte inside the image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= 11'd0;
            r_rows_done   <= 12'd0;
        end else if (raster_fire) begin
            if (row_wrap) begin
                r_byte_in_row <= 11'd0;
                r_rows_done   <= r_rows_done + 12'd1;
            end else begin
                r_byte_in_row <= byte_next[10:0];
            end
        end
    end

    // Unpack stage: load a byte, then step one pixel per output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_busy <= 1'b0;
        end else if (raster_fire) begin
            r_a_busy <= n_cnt != 4'd0;
        end else if (a_adv && a_last) begin
            r_a_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (raster_fire) begin
            r_a_byte   <= i_item.data.raster_byte;
            r_a_cnt    <= n_cnt;
            r_a_x      <= x0[10:0];
            r_a_y      <= y_full[10:0];
            r_a_imgend <= img_end;
            r_a_depth  <= r_depth;
        end else if (a_adv) begin
            r_a_byte <= n_a_byte;
            r_a_cnt  <= r_a_cnt - 4'd1;
            r_a_x    <= r_a_x + 11'd1;
        end
    end

    // Palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[i_item.data.palette_index[PAL_AW-1:0]] <=
                {i_item.data.entry_red, i_item.data.entry_green, i_item.data.entry_blue};
        end
        if (a_adv) begin
            r_rgb <= r_pal[cidx[PAL_AW-1:0]];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (a_adv) begin
            r_ovalid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_ox    <= r_a_x;
            r_oy    <= r_a_y;
            r_olast <= a_last;
            r_odone <= a_last && r_a_imgend;
            r_ozero <= {1'b0, cidx} >= PAL_LIMIT;
        end
    end

    assign o_pixel.valid             = r_ovalid;
    assign o_pixel.data.pixel_x      = r_ox;
    assign o_pixel.data.pixel_y      = r_oy;
    assign o_pixel.data.pixel_red    = r_ozero ? 8'd0 : r_rgb[23:16];
    assign o_pixel.data.pixel_green  = r_ozero ? 8'd0 : r_rgb[15:8];
    assign o_pixel.data.pixel_blue   = r_ozero ? 8'd0 : r_rgb[7:0];
    assign o_pixel.data.last_of_byte = r_olast;
    assign o_pixel.data.image_done   = r_odone;

    // No new item while the unpack stage still owes pixels of its byte
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (!r_a_busy || (a_adv && r_a_cnt == 4'd1)))
        else $error("item taken while a byte is still being unpacked");

    // The end of the image is always the last pixel of its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && o_pixel.data.image_done) |-> o_pixel.data.last_of_byte)
        else $error("image end flagged on a pixel that is not last of its byte");

    // A stalled pixel stays in the output register while the unpack stage is idle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_pixel.ready && !r_a_busy) |=> r_ovalid)
        else $error("stalled pixel dropped from the output register");

endmodule

// ----- test/tb.sv -----
// Testbench for the indexed bitmap pixel unpacker core: directed table, then random images.
// Depends on ibpu_pkg, the channel interfaces in ibpu_if.sv and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ibpu_pkg::*;

    localparam logic [1:0] DEPTH_AS_8BIT = 2'd3;   // undefined code, decodes as 8 bits
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 190;
    localparam int WIDE_BYTES      = 32;

    // One row of stimulus: a register write or an input item
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [31:0] value;
        t_item       it;
        int          n_typed;   // -1: use the predictor, 0 or 1: typed expectation count
        t_pixel      exp;
    } t_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ibpu_item_if  item_if ();
    ibpu_pixel_if pixel_if ();

    indexed_bitmap_pixel_unpacker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_item  (item_if),
        .o_pixel (pixel_if)
    );

    // Predictor state
    logic [23:0] palette_model [256];
    logic [1:0]  depth_reg;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    int          col_byte;
    int          rows_cnt;
    t_pixel      decoded [8];
    int          n_decoded;

    // Traffic state
    t_step  item_backlog [$];
    t_pixel awaited [$];
    bit     running;
    bit     took;
    int     src_idle;
    int     snk_idle;
    int     hold_cycles;
    int     quiet;
    int     errors;
    int     items_taken;
    int     pixels_checked;
    int     cfg_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clamp_dim(input int v);
        if (v < 1) return 1;
        if (v > DIM_CAP) return DIM_CAP;
        return v;
    endfunction

    function automatic int bits_for(input logic [1:0] code);
        if (code == DEPTH_1BIT) return 1;
        if (code == DEPTH_4BIT) return 4;
        return 8;
    endfunction

    function automatic int row_bytes(input int w, input int bpp);
        return (((w * bpp + 7) / 8) + 3) & ~3;
    endfunction

    function automatic logic [31:0] held_value(input logic [1:0] idx);
        case (idx)
            REG_DEPTH:  return 32'(depth_reg);
            REG_WIDTH:  return 32'(width_reg);
            default:    return 32'(height_reg);
        endcase
    endfunction

    function automatic t_item raster_item(input logic [7:0] b);
        t_item it;
        it.mode          = MODE_RASTER;
        it.palette_index = 8'($urandom);
        it.entry_red     = 8'($urandom);
        it.entry_green   = 8'($urandom);
        it.entry_blue    = 8'($urandom);
        it.raster_byte   = b;
        return it;
    endfunction

    function automatic t_item palette_item(input logic [7:0] idx, input logic [7:0] r,
                                           input logic [7:0] g, input logic [7:0] b);
        t_item it;
        it.mode          = MODE_PALETTE;
        it.palette_index = idx;
        it.entry_red     = r;
        it.entry_green   = g;
        it.entry_blue    = b;
        it.raster_byte   = 8'($urandom);
        return it;
    endfunction

    function automatic t_step item_step(input t_item it, input int n_typed, input t_pixel exp);
        t_step st;
        st.is_cfg  = 1'b0;
        st.reg_idx = REG_DEPTH;
        st.value   = '0;
        st.it      = it;
        st.n_typed = n_typed;
        st.exp     = exp;
        return st;
    endfunction

    function automatic t_step cfg_step(input logic [1:0] idx, input logic [31:0] value);
        t_step st;
        st = item_step('0, 0, '0);
        st.is_cfg  = 1'b1;
        st.reg_idx = idx;
        st.value   = value;
        return st;
    endfunction

    function automatic t_pixel pixel_of(input int x, input int y, input logic [7:0] r,
                                        input logic [7:0] g, input logic [7:0] b,
                                        input bit last, input bit done);
        t_pixel p;
        p.pixel_x      = 11'(x);
        p.pixel_y      = 11'(y);
        p.pixel_red    = r;
        p.pixel_green  = g;
        p.pixel_blue   = b;
        p.last_of_byte = last;
        p.image_done   = done;
        return p;
    endfunction

    // Decode one accepted item into the pixels it must yield
    task automatic unpack_item(input t_item it);
        int w, h, bpp, ppb, rl, x0, x, k, ci;
        bit last_row;
        logic [23:0] col;
        n_decoded = 0;
        if (it.mode == MODE_PALETTE) begin
            palette_model[it.palette_index] = {it.entry_red, it.entry_green, it.entry_blue};
            return;
        end
        w = clamp_dim(int'(width_reg));
        h = clamp_dim(int'(height_reg));
        // drop bytes past the last row without touching the counters
        if (rows_cnt >= h) return;
        bpp = bits_for(depth_reg);
        ppb = 8 / bpp;
        rl  = row_bytes(w, bpp);
        x0  = col_byte * ppb;
        last_row = (rows_cnt == h - 1);
        for (k = 0; k < ppb && x0 + k < w; k++) begin
            x   = x0 + k;
            ci  = (int'(it.raster_byte) >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
            col = palette_model[ci];
            decoded[k] = pixel_of(x, h - 1 - rows_cnt, col[23:16], col[15:8], col[7:0],
                                  1'b0, last_row && (x == w - 1));
            n_decoded++;
        end
        if (n_decoded > 0) decoded[n_decoded - 1].last_of_byte = 1'b1;
        // advance the byte position, wrap into the next row
        col_byte++;
        if (col_byte >= rl) begin
            col_byte = 0;
            rows_cnt = (rows_cnt + 1) & 12'hfff;
        end
        col_byte &= 11'h7ff;
    endtask

    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register with junk in the unused bits, then read it back
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] keep, rd;
        keep = (idx == REG_DEPTH) ? 32'h3 : 32'hfff;
        apb_xfer(1'b1, idx, (value & keep) | ($urandom & ~keep), rd);
        case (idx)
            REG_DEPTH:  depth_reg  = value[1:0];
            REG_WIDTH:  width_reg  = value[11:0];
            default:    height_reg = value[11:0];
        endcase
        cfg_writes++;
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== held_value(idx)) begin
            $error("register %0d readback: expected %0h, got %0h", idx, held_value(idx), rd);
            errors++;
        end
    endtask

    // Let the block drain, plus its pipeline depth for items with no pixels
    task automatic wait_idle();
        while (item_backlog.size() != 0 || awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offer items at the falling edge; hold each until its transfer
    always @(negedge i_clk) begin
        if (running) begin
            if (!item_if.valid || took) begin
                took = 1'b0;
                if (item_backlog.size() > 0 && $urandom_range(99) >= src_idle) begin
                    item_if.valid <= 1'b1;
                    item_if.data  <= item_backlog[0].it;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel ready, with a counted hold-off stretch on request
    always @(negedge i_clk) begin
        if (running) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                pixel_if.ready <= 1'b0;
            end else begin
                pixel_if.ready <= ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Sample both channels at the rising edge; watch for a stuck block
    always @(posedge i_clk) begin
        t_pixel want, got;
        t_step st;
        bit moved;
        if (running) begin
            moved = 1'b0;
            if (pixel_if.valid && pixel_if.ready) begin
                moved = 1'b1;
                got = pixel_if.data;
                if (awaited.size() == 0) begin
                    $error("pixel with no expectation: x %0d y %0d", got.pixel_x, got.pixel_y);
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    pixels_checked++;
                    if (got.pixel_x !== want.pixel_x) begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
                        errors++;
                    end
                    if (got.pixel_y !== want.pixel_y) begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
                        errors++;
                    end
                    if (got.pixel_red !== want.pixel_red) begin
                        $error("pixel_red: expected %0h, got %0h", want.pixel_red, got.pixel_red);
                        errors++;
                    end
                    if (got.pixel_green !== want.pixel_green) begin
                        $error("pixel_green: expected %0h, got %0h",
                               want.pixel_green, got.pixel_green);
                        errors++;
                    end
                    if (got.pixel_blue !== want.pixel_blue) begin
                        $error("pixel_blue: expected %0h, got %0h",
                               want.pixel_blue, got.pixel_blue);
                        errors++;
                    end
                    if (got.last_of_byte !== want.last_of_byte) begin
                        $error("last_of_byte: expected %0b, got %0b",
                               want.last_of_byte, got.last_of_byte);
                        errors++;
                    end
                    if (got.image_done !== want.image_done) begin
                        $error("image_done: expected %0b, got %0b",
                               want.image_done, got.image_done);
                        errors++;
                    end
                end
            end
            if (item_if.valid && item_if.ready) begin
                moved = 1'b1;
                st = item_backlog.pop_front();
                took = 1'b1;
                items_taken++;
                unpack_item(st.it);
                if (st.n_typed < 0) begin
                    for (int i = 0; i < n_decoded; i++) awaited.push_back(decoded[i]);
                end else if (st.n_typed == 1) begin
                    awaited.push_back(st.exp);
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Stopped after %0d cycles with no transfer; %0d items taken",
                         quiet, items_taken);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_step       plan [$];
        logic [31:0] rd;
        logic [1:0]  d;
        int          w, k, nb, rand_items;
        bit          broken, big_done, first_phase, wide_row;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        item_if.valid  = 1'b0;
        item_if.data   = '0;
        pixel_if.ready = 1'b0;
        running        = 1'b0;
        took           = 1'b0;
        hold_cycles    = 0;
        quiet          = 0;
        errors         = 0;
        items_taken    = 0;
        pixels_checked = 0;
        cfg_writes     = 0;
        depth_reg      = RST_DEPTH;
        width_reg      = RST_WIDTH;
        height_reg     = RST_HEIGHT;
        col_byte       = 0;
        rows_cnt       = 0;
        src_idle       = 37;
        snk_idle       = 64;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;

        // Check reset values of the registers
        for (int r = 0; r < 3; r++) begin
            apb_xfer(1'b0, 2'(r), '0, rd);
            if (rd !== held_value(2'(r))) begin
                $error("register %0d after reset: expected %0h, got %0h",
                       r, held_value(2'(r)), rd);
                errors++;
            end
        end

        // Fill the whole palette so that no unwritten entry is ever read
        for (int i = 0; i < 256; i++)
            item_backlog.push_back(item_step(palette_item(8'(i), 8'($urandom), 8'($urandom),
                                                          8'($urandom)), -1, '0));

        // Directed table
        plan.push_back(cfg_step(REG_WIDTH, 32'd2));
        plan.push_back(cfg_step(REG_HEIGHT, 32'hffff_ffff));   // saturates to the cap
        plan.push_back(item_step(palette_item(8'h00, 8'h00, 8'h00, 8'h00), 0, '0));
        plan.push_back(item_step(palette_item(8'hff, 8'hff, 8'hff, 8'hff), 0, '0));
        plan.push_back(item_step(raster_item(8'hff), 1,
                                 pixel_of(0, 2047, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0)));
        plan.push_back(item_step(raster_item(8'h00), 1,
                                 pixel_of(1, 2047, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0)));
        plan.push_back(item_step(raster_item(8'($urandom)), 0, '0));   // row padding
        plan.push_back(item_step(raster_item(8'($urandom)), 0, '0));
        // one bit per pixel, trailing bits past the width
        plan.push_back(cfg_step(REG_DEPTH, 32'(DEPTH_1BIT)));
        plan.push_back(cfg_step(REG_HEIGHT, 32'd3));
        plan.push_back(item_step(raster_item(8'h80), -1, '0));
        for (int i = 0; i < 3; i++) plan.push_back(item_step(raster_item(8'($urandom)), 0, '0));
        // undefined depth code and zero width, last row of the image
        plan.push_back(cfg_step(REG_DEPTH, 32'(DEPTH_AS_8BIT)));
        plan.push_back(cfg_step(REG_WIDTH, 32'd0));
        plan.push_back(item_step(raster_item(8'hff), 1,
                                 pixel_of(0, 0, 8'hff, 8'hff, 8'hff, 1'b1, 1'b1)));
        for (int i = 0; i < 3; i++) plan.push_back(item_step(raster_item(8'($urandom)), 0, '0));
        plan.push_back(item_step(raster_item(8'($urandom)), 0, '0));   // past the image
        plan.push_back(item_step(palette_item(8'($urandom), 8'($urandom), 8'($urandom),
                                              8'($urandom)), 0, '0));
        // shrink the row while in the middle of it
        plan.push_back(cfg_step(REG_DEPTH, 32'(DEPTH_8BIT)));
        plan.push_back(cfg_step(REG_WIDTH, 32'd8));
        plan.push_back(cfg_step(REG_HEIGHT, 32'd6));
        for (int i = 0; i < 4; i++) plan.push_back(item_step(raster_item(8'($urandom)), -1, '0));
        plan.push_back(cfg_step(REG_WIDTH, 32'd1));
        plan.push_back(item_step(raster_item(8'($urandom)), -1, '0));
        plan.push_back(item_step(raster_item(8'($urandom)), -1, '0));

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_idle();
                cfg_write(plan[i].reg_idx, plan[i].value);
            end else begin
                item_backlog.push_back(plan[i]);
            end
        end

        // Random images, one setting per phase
        rand_items  = 0;
        big_done    = 1'b0;
        first_phase = 1'b1;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items < 60) begin
                src_idle = 37;
                snk_idle = 64;
            end else if (rand_items < 120) begin
                src_idle = 64;
                snk_idle = 37;
            end else begin
                src_idle = 0;
                snk_idle = 0;
            end
            wait_idle();
            wide_row = 1'b0;
            if (rand_items >= 120 && !big_done) begin
                // start of the widest row at one bit per pixel
                big_done = 1'b1;
                wide_row = 1'b1;
                d  = DEPTH_1BIT;
                w  = 4095;
                k  = 1;
                broken = 1'b1;
            end else begin
                d = 2'($urandom_range(3));
                case ($urandom_range(9))
                    0:       w = 0;
                    1, 2:    w = $urandom_range(25, 64);
                    default: w = $urandom_range(1, 24);
                endcase
                k = $urandom_range(1, 3);
                broken = ($urandom_range(3) == 0);
            end
            cfg_write(REG_DEPTH, 32'(d));
            cfg_write(REG_WIDTH, 32'(w));
            cfg_write(REG_HEIGHT, 32'(rows_cnt + k));
            if (first_phase) begin
                first_phase = 1'b0;
                hold_cycles = HOLD_OFF_CYCLES;
            end
            nb = k * row_bytes(clamp_dim(w), bits_for(d));
            if (wide_row) nb = WIDE_BYTES;
            else if (broken) nb = $urandom_range(1, nb);
            for (int i = 0; i < nb; i++) begin
                if ($urandom_range(9) == 0) begin
                    item_backlog.push_back(item_step(palette_item(8'($urandom), 8'($urandom),
                                                                  8'($urandom), 8'($urandom)),
                                                     -1, '0));
                    rand_items++;
                end
                item_backlog.push_back(item_step(raster_item(8'($urandom)), -1, '0));
                rand_items++;
            end
            // trailing bytes past the image
            if (!broken) begin
                for (int i = $urandom_range(2); i > 0; i--)
                    item_backlog.push_back(item_step(raster_item(8'($urandom)), -1, '0));
            end
        end

        wait_idle();
        $display("Run covered %0d input transfers and %0d checked pixels", items_taken,
                 pixels_checked);
        $display("over %0d register writes at 1, 4 and 8 bits per pixel", cfg_writes);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
